// ===== rtl/fcfl_pkg.sv =====
package fcfl_pkg;

   localparam int IDX_W     = 10;
   localparam int LINK_W    = 11;
   localparam int TOTAL_W   = 11;
   localparam int BYTES_W   = 16;
   localparam int OFFS_W    = 26;
   localparam int CSR_IDX_W = 1;
   localparam int INDEX_CAP = 1024;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_TOTAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK_BYTES = 1'd1;

   localparam logic [LINK_W-1:0]  NULL_MARK   = 11'h400;
   localparam logic [BYTES_W-1:0] BYTES_RESET = 16'd8;

   typedef struct packed {
      logic accept;
      logic exec;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic busy;
   } dp_status_type;

endpackage

// ===== rtl/fcfl_ifs.sv =====
interface fcfl_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [fcfl_pkg::IDX_W-1:0] release_index;

   modport source (output valid, output opcode, output release_index, input ready);
   modport sink   (input valid, input opcode, input release_index, output ready);
endinterface

interface fcfl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        granted;
   logic [fcfl_pkg::IDX_W-1:0]  given_index;
   logic [fcfl_pkg::OFFS_W-1:0] byte_offset;

   modport source (output valid, output granted, output given_index, output byte_offset,
                   input ready);
   modport sink   (input valid, input granted, input given_index, input byte_offset,
                   output ready);
endinterface

interface fcfl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fcfl_pkg::CSR_IDX_W-1:0] index;
   logic [fcfl_pkg::BYTES_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fcfl_ctrl.sv =====
module fcfl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  fcfl_pkg::dp_status_type status,
   output fcfl_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.exec   = 1'b0;
      cmd.load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !status.busy;
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (slot_free) begin
               cmd.load  = 1'b1;
               req_ready = !status.busy;
               if (req_valid && req_ready) begin
                  cmd.accept = 1'b1;
                  state_in   = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/fcfl_dpath.sv =====
module fcfl_dpath #(
   parameter int DEPTH = 1024,
   parameter int ALIGN = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fcfl_pkg::ctrl_cmd_type            cmd,
   output fcfl_pkg::dp_status_type           status,
   input  logic                              req_opcode,
   input  logic [fcfl_pkg::IDX_W-1:0]        req_release_index,
   output logic                              rsp_granted,
   output logic [fcfl_pkg::IDX_W-1:0]        rsp_given_index,
   output logic [fcfl_pkg::OFFS_W-1:0]       rsp_byte_offset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fcfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fcfl_pkg::BYTES_W-1:0]      csr_data
);

   localparam int MEM_DEPTH = (DEPTH < fcfl_pkg::INDEX_CAP) ? DEPTH : fcfl_pkg::INDEX_CAP;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int SZ_W      = fcfl_pkg::BYTES_W + 1;
   localparam int SHIFT     = 24;
   localparam int RCP_W     = SHIFT + 1;
   localparam int QP_W      = SZ_W + RCP_W;
   localparam int PROD_W    = fcfl_pkg::IDX_W + SZ_W;
   localparam logic [fcfl_pkg::TOTAL_W-1:0] CAP  = fcfl_pkg::TOTAL_W'(MEM_DEPTH);
   localparam logic [RCP_W-1:0]             RCP  = RCP_W'((2**SHIFT + ALIGN - 1) / ALIGN);
   localparam logic [6:0]                   ALGN = 7'(ALIGN);
   localparam int NULL_BIT = fcfl_pkg::LINK_W - 1;

   logic [fcfl_pkg::LINK_W-1:0]  link_mem [MEM_DEPTH];

   logic [fcfl_pkg::TOTAL_W-1:0] total_ff;
   logic [fcfl_pkg::BYTES_W-1:0] bytes_ff;
   logic [fcfl_pkg::LINK_W-1:0]  head_ff, head_in;
   logic [fcfl_pkg::TOTAL_W-1:0] fresh_ff, fresh_in;
   logic [1:0]                   settle_ff, settle_in;
   logic [SZ_W-1:0]              quot_ff;
   logic [SZ_W-1:0]              aligned_ff;
   logic [fcfl_pkg::LINK_W-1:0]  link_rd_ff;
   logic                         op_ff;
   logic [fcfl_pkg::IDX_W-1:0]   rel_ff;
   logic                         gnt_ff;
   logic [fcfl_pkg::IDX_W-1:0]   idx_ff;
   logic                         out_gnt_ff;
   logic [fcfl_pkg::IDX_W-1:0]   out_idx_ff;
   logic [fcfl_pkg::OFFS_W-1:0]  out_offs_ff;

   logic                         cfg_wr;
   logic [fcfl_pkg::TOTAL_W-1:0] limit;
   logic                         head_live;
   logic                         gnt_in;
   logic [fcfl_pkg::IDX_W-1:0]   idx_in;
   logic                         wr_en;
   logic [SZ_W-1:0]              rounded;
   logic [QP_W-1:0]              quot_prod;
   logic [PROD_W-1:0]            offs_prod;

   assign csr_ready     = 1'b1;
   assign cfg_wr        = csr_valid && csr_ready;
   assign status.busy   = settle_ff != 2'd0;

   assign limit = (bytes_ff == '0) ? '0 : ((total_ff > CAP) ? CAP : total_ff);
   assign head_live = !head_ff[NULL_BIT] && (head_ff < limit);

   assign rounded   = SZ_W'(bytes_ff) + SZ_W'(ALIGN - 1);
   assign quot_prod = QP_W'(rounded) * QP_W'(RCP);
   assign offs_prod = PROD_W'(idx_ff) * PROD_W'(aligned_ff);

   assign settle_in = cfg_wr ? 2'd2 : ((settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0);

   always_comb begin
      head_in  = head_ff;
      fresh_in = fresh_ff;
      gnt_in   = 1'b0;
      idx_in   = '0;
      wr_en    = 1'b0;
      if (cfg_wr) begin
         head_in  = fcfl_pkg::NULL_MARK;
         fresh_in = '0;
      end else if (cmd.exec) begin
         if (op_ff == fcfl_pkg::OP_FREE) begin
            if (fcfl_pkg::TOTAL_W'(rel_ff) < limit) begin
               wr_en   = 1'b1;
               head_in = fcfl_pkg::LINK_W'(rel_ff);
               gnt_in  = 1'b1;
            end
         end else if (limit != '0) begin
            if (head_live) begin
               idx_in  = head_ff[fcfl_pkg::IDX_W-1:0];
               head_in = link_rd_ff;
               gnt_in  = 1'b1;
            end else if (!head_ff[NULL_BIT]) begin
               head_in = fcfl_pkg::NULL_MARK;
            end
            if (!gnt_in && (fresh_ff < limit)) begin
               idx_in   = fresh_ff[fcfl_pkg::IDX_W-1:0];
               fresh_in = fresh_ff + 1'b1;
               gnt_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         bytes_ff  <= fcfl_pkg::BYTES_RESET;
         head_ff   <= fcfl_pkg::NULL_MARK;
         fresh_ff  <= '0;
         settle_ff <= 2'd2;
      end else begin
         if (cfg_wr) begin
            unique case (csr_index)
               fcfl_pkg::REG_CHUNK_TOTAL: total_ff <= csr_data[fcfl_pkg::TOTAL_W-1:0];
               fcfl_pkg::REG_CHUNK_BYTES: bytes_ff <= csr_data;
               default: ;
            endcase
         end
         head_ff   <= head_in;
         fresh_ff  <= fresh_in;
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_prod[SHIFT +: SZ_W];
      aligned_ff <= SZ_W'(quot_ff * ALGN);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[rel_ff[AW-1:0]] <= head_ff;
      end
      link_rd_ff <= link_mem[head_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_opcode;
         rel_ff <= req_release_index;
      end
      if (cmd.exec) begin
         gnt_ff <= gnt_in;
         idx_ff <= idx_in;
      end
      if (cmd.load) begin
         out_gnt_ff  <= gnt_ff;
         out_idx_ff  <= idx_ff;
         out_offs_ff <= offs_prod[fcfl_pkg::OFFS_W-1:0];
      end
   end

   assign rsp_granted     = out_gnt_ff;
   assign rsp_given_index = out_idx_ff;
   assign rsp_byte_offset = out_offs_ff;

endmodule

// ===== rtl/fixed_chunk_free_list_allocator.sv =====
// Chunk pool allocator: each request word either allocates a chunk (popping the LIFO free
// list, or else handing out the next never-issued index) or frees one, and yields exactly one
// response word with grant flag, index and byte offset. The link memory delivers the
// registered read at the list head, the grant and index are registered, and the offset
// multiply goes into the output register once the response slot is free; the next request
// can be taken as that register is loaded. A configuration write re-creates the pool and
// holds off requests while the aligned chunk size is recomputed. The link memory is not
// cleared; only links written by earlier frees are ever read.
module fixed_chunk_free_list_allocator #(
   parameter int DEPTH = 1024,
   parameter int ALIGN = 8
) (
   input logic         clock,
   input logic         reset,
   fcfl_req_if.sink    req_if,
   fcfl_rsp_if.source  rsp_if,
   fcfl_csr_if.sink    csr_if
);

   fcfl_pkg::ctrl_cmd_type  cmd;
   fcfl_pkg::dp_status_type status;

   fcfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .status    (status),
      .cmd       (cmd)
   );

   fcfl_dpath #(
      .DEPTH (DEPTH),
      .ALIGN (ALIGN)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_if.opcode),
      .req_release_index (req_if.release_index),
      .rsp_granted       (rsp_if.granted),
      .rsp_given_index   (rsp_if.given_index),
      .rsp_byte_offset   (rsp_if.byte_offset),
      .csr_valid         (csr_if.valid),
      .csr_ready         (csr_if.ready),
      .csr_index         (csr_if.index),
      .csr_data          (csr_if.data)
   );

endmodule
